[design/assert_macros.svh]
// Assertion macros used by the edge-map RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GDTE_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (prop)) \
        else $error("gdte assertion failed");
`define GDTE_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) !(cond)) \
        else $error("gdte forbidden condition");
`else
`define GDTE_ASSERT(lbl, ck, rn, prop)
`define GDTE_NEVER(lbl, ck, rn, cond)
`endif
`endif

[design/gdte_pkg.sv]
// Shared types and constants for the gradient double-threshold edge block.
// No dependencies; imported by every module of the block.
package gdte_pkg;

    localparam int CFG_W   = 11;
    localparam int TH_W    = 9;
    localparam int PIX_W   = 8;
    localparam int IDX_W   = 2;
    localparam int MIN_DIM = 3;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd480;
    localparam logic [TH_W-1:0]  RST_LOW    = 9'd30;
    localparam logic [TH_W-1:0]  RST_HIGH   = 9'd80;

    // (low+1)^2 needs one bit more than high^2
    localparam int LO_SQ_W = 2 * (TH_W + 1) - 1;
    localparam int HI_SQ_W = 2 * TH_W;
    localparam int GSQ_W   = 2 * PIX_W + 1;

    localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_LOW,
        REG_HIGH
    } cfg_reg_t;

    typedef enum logic {
        OP_PIXEL,
        OP_DRAIN
    } opcode_t;

    typedef struct packed {
        logic raw_wr;   // pixel goes into the raw line store
        logic p1_wr;    // pass-one result is written to its line store
        logic p1_keep;  // pass-one pixel in last row or column keeps grey value
        logic emit;     // request produces a result
        logic border;   // result pixel lies on the frame border
        logic last;     // result is the last pixel of the frame
    } item_flags_t;

endpackage

[design/gdte_ctrl.sv]
// Frame sequencing: raster counters, per-frame geometry latch, per-request flags.
// Depends on gdte_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gdte_ctrl
    import gdte_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              opcode,
    input  logic [CFG_W-1:0]  width_cfg,
    input  logic [CFG_W-1:0]  height_cfg,
    output logic              item_en,
    output logic [CW-1:0]     wr_col,
    output logic [CW-1:0]     rd_col,
    output item_flags_t       flags
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int W_RST = (int'(RST_WIDTH) > MAX_WIDTH) ? MAX_WIDTH : int'(RST_WIDTH);
    localparam int H_RST = (int'(RST_HEIGHT) > MAX_HEIGHT) ? MAX_HEIGHT : int'(RST_HEIGHT);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [WW-1:0] frame_w_reg, frame_w_next;
    logic [HW-1:0] frame_h_reg, frame_h_next;

    logic [WW-1:0] w_clamp, cur_w;
    logic [HW-1:0] h_clamp, cur_h;
    logic [RW-1:0] h_ext;
    logic          start, in_frame, col_last, c0, c1;

    always_comb
    begin
        if (width_cfg < CFG_W'(MIN_DIM))
            w_clamp = WW'(MIN_DIM);
        else if (32'(width_cfg) > MAX_WIDTH)
            w_clamp = WW'(MAX_WIDTH);
        else
            w_clamp = WW'(width_cfg);

        if (height_cfg < CFG_W'(MIN_DIM))
            h_clamp = HW'(MIN_DIM);
        else if (32'(height_cfg) > MAX_HEIGHT)
            h_clamp = HW'(MAX_HEIGHT);
        else
            h_clamp = HW'(height_cfg);
    end

    // geometry is taken from the registers on the first request of a frame
    assign start    = (row_reg == '0) && (col_reg == '0);
    assign cur_w    = start ? w_clamp : frame_w_reg;
    assign cur_h    = start ? h_clamp : frame_h_reg;
    assign h_ext    = RW'(cur_h);
    assign in_frame = row_reg < h_ext;
    assign col_last = WW'(col_reg) == (cur_w - WW'(1));
    assign c0       = col_reg == '0;
    assign c1       = col_reg == CW'(1);

    // a drain inside the frame is dropped without effect
    assign item_en = accept && !((opcode == OP_DRAIN) && in_frame);
    assign wr_col  = col_reg;
    assign rd_col  = col_last ? '0 : col_reg + CW'(1);

    // output pixel trails by 2*width+1: column c-1 of row r-2 (wraps at column 0)
    always_comb
    begin
        flags.raw_wr  = in_frame;
        flags.p1_wr   = (row_reg != '0) && (row_reg <= h_ext);
        flags.p1_keep = (row_reg == h_ext) || col_last;
        flags.emit    = (row_reg >= RW'(3)) || ((row_reg == RW'(2)) && !c0);
        flags.last    = (row_reg == h_ext + RW'(2)) && c0;
        flags.border  = c0 || c1
                      || (c0 ? (row_reg == RW'(3)) : (row_reg == RW'(2)))
                      || (c0 ? (row_reg == h_ext + RW'(2)) : (row_reg == h_ext + RW'(1)));
    end

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        frame_w_next = frame_w_reg;
        frame_h_next = frame_h_reg;
        if (accept && start)
        begin
            frame_w_next = w_clamp;
            frame_h_next = h_clamp;
        end
        if (item_en)
        begin
            if (flags.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_last)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            frame_w_reg <= WW'(W_RST);
            frame_h_reg <= HW'(H_RST);
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            frame_w_reg <= frame_w_next;
            frame_h_reg <= frame_h_next;
        end
    end

    `GDTE_ASSERT(a_col_in_frame, clk, rst_n, !start |-> (WW'(col_reg) < frame_w_reg))
    `GDTE_ASSERT(a_row_bound, clk, rst_n, row_reg <= RW'(frame_h_reg) + RW'(2))
    `GDTE_ASSERT(a_tail_row_single, clk, rst_n, (row_reg == h_ext + RW'(2)) |-> c0)
    `GDTE_ASSERT(a_frame_wrap, clk, rst_n, (item_en && flags.last) |=> start)

endmodule

[design/gdte_pass_one.sv]
// Pass one: raw line store, forward-difference gradients, double threshold.
// Depends on gdte_pkg.
module gdte_pass_one
    import gdte_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                item_en,
    input  logic [PIX_W-1:0]    pixel,
    input  logic [CW-1:0]       wr_col,
    input  logic [CW-1:0]       rd_col,
    input  item_flags_t         flags,
    input  logic [LO_SQ_W-1:0]  lo_sq,
    input  logic [HI_SQ_W-1:0]  hi_sq,
    output logic                p_valid,
    output logic [PIX_W-1:0]    p_value,
    output logic [CW-1:0]       p_col,
    output item_flags_t         p_flags
);

    localparam int SQ_W = 2 * PIX_W;

    logic [PIX_W-1:0] raw_mem [MAX_WIDTH];
    logic [PIX_W-1:0] raw_rd_reg;

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, p_valid_reg;
    logic [PIX_W-1:0]  s1_pix_reg, s1_rawq_reg, s2_c_reg, s3_c_reg, p_value_reg;
    logic [PIX_W-1:0]  s2_dx_reg, s2_dy_reg;
    logic [SQ_W-1:0]   s3_sx_reg, s3_sy_reg;
    logic [CW-1:0]     s1_col_reg, s2_col_reg, s3_col_reg, p_col_reg;
    item_flags_t       s1_flags_reg, s2_flags_reg, s3_flags_reg, p_flags_reg;

    logic [PIX_W-1:0]  dx, dy, p1_value;
    logic [GSQ_W-1:0]  g2;

    // read one column ahead; the previous read is the pixel one row up
    always_ff @(posedge clk)
    begin
        if (item_en)
        begin
            if (flags.raw_wr)
                raw_mem[wr_col] <= pixel;
            raw_rd_reg <= raw_mem[rd_col];
        end
    end

    // raw_rd_reg: right neighbor one row up; s1_rawq_reg: pixel one row up
    assign dx = (raw_rd_reg >= s1_rawq_reg) ? raw_rd_reg - s1_rawq_reg
                                            : s1_rawq_reg - raw_rd_reg;
    assign dy = (s1_pix_reg >= s1_rawq_reg) ? s1_pix_reg - s1_rawq_reg
                                            : s1_rawq_reg - s1_pix_reg;

    assign g2 = GSQ_W'(s3_sx_reg) + GSQ_W'(s3_sy_reg);

    // low test wins when thresholds overlap
    always_comb
    begin
        if (s3_flags_reg.p1_keep)
            p1_value = s3_c_reg;
        else if (LO_SQ_W'(g2) < lo_sq)
            p1_value = PIX_ZERO;
        else if (HI_SQ_W'(g2) >= hi_sq)
            p1_value = PIX_MAX;
        else
            p1_value = s3_c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= item_en;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            p_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg   <= pixel;
            s1_rawq_reg  <= raw_rd_reg;
            s1_col_reg   <= wr_col;
            s1_flags_reg <= flags;

            s2_dx_reg    <= dx;
            s2_dy_reg    <= dy;
            s2_c_reg     <= s1_rawq_reg;
            s2_col_reg   <= s1_col_reg;
            s2_flags_reg <= s1_flags_reg;

            s3_sx_reg    <= SQ_W'(s2_dx_reg) * SQ_W'(s2_dx_reg);
            s3_sy_reg    <= SQ_W'(s2_dy_reg) * SQ_W'(s2_dy_reg);
            s3_c_reg     <= s2_c_reg;
            s3_col_reg   <= s2_col_reg;
            s3_flags_reg <= s2_flags_reg;

            p_value_reg  <= p1_value;
            p_col_reg    <= s3_col_reg;
            p_flags_reg  <= s3_flags_reg;
        end
    end

    assign p_valid = p_valid_reg;
    assign p_value = p_value_reg;
    assign p_col   = p_col_reg;
    assign p_flags = p_flags_reg;

endmodule

[design/gdte_pass_two.sv]
// Pass two: two-row pass-one line store, 3x3 window, hysteresis decision.
// Depends on gdte_pkg.
module gdte_pass_two
    import gdte_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              p_valid,
    input  logic [PIX_W-1:0]  p_value,
    input  logic [CW-1:0]     p_col,
    input  item_flags_t       p_flags,
    output logic              res_valid,
    output logic [PIX_W-1:0]  res_pixel,
    output logic              res_last
);

    localparam int ROW2_W = 2 * PIX_W;

    // entry per column: {row above, two rows above} relative to the incoming row
    logic [ROW2_W-1:0] p1_mem [MAX_WIDTH];
    logic [ROW2_W-1:0] q_rd_reg;

    logic              q_valid_reg, r_valid_reg;
    logic [PIX_W-1:0]  q_value_reg;
    logic [CW-1:0]     q_col_reg;
    item_flags_t       q_flags_reg, r_flags_reg;

    logic [PIX_W-1:0]  win_top_reg [3];
    logic [PIX_W-1:0]  win_mid_reg [3];
    logic [PIX_W-1:0]  win_bot_reg [3];

    logic [PIX_W-1:0]  center;
    logic              hit;

    // read-modify-write; the same column comes back at least width requests later
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_rd_reg <= p1_mem[p_col];
            if (q_valid_reg && q_flags_reg.p1_wr)
                p1_mem[q_col_reg] <= {q_value_reg, q_rd_reg[ROW2_W-1:PIX_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            q_valid_reg <= p_valid;
            r_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_value_reg <= p_value;
            q_col_reg   <= p_col;
            q_flags_reg <= p_flags;
            r_flags_reg <= q_flags_reg;
            if (q_valid_reg)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    win_top_reg[k] <= win_top_reg[k+1];
                    win_mid_reg[k] <= win_mid_reg[k+1];
                    win_bot_reg[k] <= win_bot_reg[k+1];
                end
                win_top_reg[2] <= q_rd_reg[PIX_W-1:0];
                win_mid_reg[2] <= q_rd_reg[ROW2_W-1:PIX_W];
                win_bot_reg[2] <= q_value_reg;
            end
        end
    end

    assign center = win_mid_reg[1];
    assign hit = (win_top_reg[0] == PIX_MAX) || (win_top_reg[1] == PIX_MAX)
              || (win_top_reg[2] == PIX_MAX) || (win_mid_reg[0] == PIX_MAX)
              || (win_mid_reg[2] == PIX_MAX) || (win_bot_reg[0] == PIX_MAX)
              || (win_bot_reg[1] == PIX_MAX) || (win_bot_reg[2] == PIX_MAX);

    always_comb
    begin
        if (r_flags_reg.border || (center == PIX_ZERO) || (center == PIX_MAX))
            res_pixel = center;
        else if (hit)
            res_pixel = PIX_MAX;
        else
            res_pixel = PIX_ZERO;
    end

    assign res_valid = r_valid_reg && r_flags_reg.emit;
    assign res_last  = r_flags_reg.last;

endmodule

[design/gradient_double_threshold_edges.sv]
// Top level of the streaming two-pass edge map with double-threshold hysteresis.
// Depends on gdte_pkg, gdte_ctrl, gdte_pass_one and gdte_pass_two.

// Takes one grey pixel (or drain request) per clock and returns at most one
// edge-map pixel per request. The result for a pixel comes out with the request
// 2*width+1 places later in the stream, so a frame needs 2*width+1 drain requests
// after its last pixel; the final result carries frame_end. Each request passes
// registers s1, s2, s3, p (pass one), q, r (pass two) and the output register.
// The rate is one request per clock, set by one access per request to each of the
// two line stores: a width-deep raw pixel line and a width-deep store holding two
// rows of pass-one results, each read once and written at most once per request.
// A result held under out_stall freezes the whole pipeline. Geometry is latched
// at the first request of a frame and clamped to 3..MAX_WIDTH by 3..MAX_HEIGHT;
// thresholds apply at once. The line stores need no clearing after reset.
module gradient_double_threshold_edges
    import gdte_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [PIX_W-1:0]  pixel_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PIX_W-1:0]  pixel_out,
    output logic              frame_end,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0]   width_reg, height_reg;
    logic [TH_W-1:0]    low_reg, high_reg;
    logic [LO_SQ_W-1:0] lo_sq_reg;
    logic [HI_SQ_W-1:0] hi_sq_reg;
    logic [TH_W:0]      low_p1;

    logic              out_valid_reg, frame_end_reg;
    logic [PIX_W-1:0]  pixel_out_reg;

    logic              adv, accept, item_en;
    logic [CW-1:0]     wr_col, rd_col, p_col;
    item_flags_t       flags, p_flags;
    logic              p_valid, res_valid, res_last;
    logic [PIX_W-1:0]  p_value, res_pixel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            low_reg    <= RST_LOW;
            high_reg   <= RST_HIGH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_LOW:    low_reg    <= cfg_data[TH_W-1:0];
                REG_HIGH:   high_reg   <= cfg_data[TH_W-1:0];
                default:    ;
            endcase
        end
    end

    // squared thresholds so the magnitude test needs no square root
    assign low_p1 = {1'b0, low_reg} + (TH_W+1)'(1);

    always_ff @(posedge clk)
    begin
        lo_sq_reg <= LO_SQ_W'(low_p1) * LO_SQ_W'(low_p1);
        hi_sq_reg <= HI_SQ_W'(high_reg) * HI_SQ_W'(high_reg);
    end

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    gdte_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (opcode),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .item_en    (item_en),
        .wr_col     (wr_col),
        .rd_col     (rd_col),
        .flags      (flags)
    );

    gdte_pass_one #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pass_one (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .item_en (item_en),
        .pixel   (pixel_in),
        .wr_col  (wr_col),
        .rd_col  (rd_col),
        .flags   (flags),
        .lo_sq   (lo_sq_reg),
        .hi_sq   (hi_sq_reg),
        .p_valid (p_valid),
        .p_value (p_value),
        .p_col   (p_col),
        .p_flags (p_flags)
    );

    gdte_pass_two #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pass_two (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .p_valid   (p_valid),
        .p_value   (p_value),
        .p_col     (p_col),
        .p_flags   (p_flags),
        .res_valid (res_valid),
        .res_pixel (res_pixel),
        .res_last  (res_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pixel_out_reg <= res_pixel;
            frame_end_reg <= res_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign frame_end = frame_end_reg;

endmodule

[sim/tb_gradient_double_threshold_edges.sv]
`timescale 1ns / 1ps
// Self-checking bench for gradient_double_threshold_edges: streams whole frames,
// predicts each edge-map pixel with a local two-pass model and checks the output.
// Depends on gdte_pkg and the gradient_double_threshold_edges RTL only.
module tb_gradient_double_threshold_edges;
    import gdte_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned FLUSH_CYC   = 16;
    localparam int unsigned RAND_REQS   = 950;
    localparam int unsigned STORE_N     = 4 * DEF_MAX_WIDTH;
    localparam int unsigned TH_TOP      = 361;

    typedef struct packed {
        opcode_t          op;
        logic [PIX_W-1:0] pix;
    } pix_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last;
    } edge_res_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    opcode_t          opcode = OP_PIXEL;
    logic [PIX_W-1:0] pixel_in = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    cfg_reg_t         cfg_index = REG_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;

    gradient_double_threshold_edges dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- edge-map predictor ----------------
    logic [CFG_W-1:0] cfg_w  = RST_WIDTH;
    logic [CFG_W-1:0] cfg_h  = RST_HEIGHT;
    logic [TH_W-1:0]  cfg_lo = RST_LOW;
    logic [TH_W-1:0]  cfg_hi = RST_HIGH;
    int unsigned      frm_w = 640;
    int unsigned      frm_h = 480;
    int unsigned      item_n, col_n, row_n;
    bit [PIX_W-1:0]   raw_mem  [0:STORE_N-1];
    bit [PIX_W-1:0]   grad_mem [0:STORE_N-1];
    edge_res_t        edge_q [$];

    function automatic int unsigned dim_clamp(int unsigned v, int unsigned top);
        if (v < MIN_DIM)
            return MIN_DIM;
        return (v > top) ? top : v;
    endfunction

    // pass one: forward-difference magnitude against both thresholds, no sqrt
    function automatic logic [PIX_W-1:0] grad_class(int unsigned q);
        int unsigned qr, qc, g2, lo1, hi;
        int gx, gy;
        logic [PIX_W-1:0] c;
        qr = q / frm_w;
        qc = q % frm_w;
        c  = raw_mem[q % STORE_N];
        if (qr == frm_h - 1 || qc == frm_w - 1)
            return c;
        gx  = int'(raw_mem[(q + 1) % STORE_N]) - int'(c);
        gy  = int'(raw_mem[(q + frm_w) % STORE_N]) - int'(c);
        g2  = gx * gx + gy * gy;
        lo1 = cfg_lo + 1;
        hi  = cfg_hi;
        if (g2 < lo1 * lo1)
            return PIX_ZERO;
        if (g2 >= hi * hi)
            return PIX_MAX;
        return c;
    endfunction

    // pass two: weak pixel survives only next to a strong one
    function automatic logic [PIX_W-1:0] hysteresis(int unsigned p, int unsigned r,
                                                     int unsigned c);
        logic [PIX_W-1:0] v;
        int dr, dc, idx;
        v = grad_mem[p % STORE_N];
        if (r == 0 || c == 0 || r == frm_h - 1 || c == frm_w - 1 ||
            v == PIX_ZERO || v == PIX_MAX)
            return v;
        for (dr = -1; dr <= 1; dr++)
            for (dc = -1; dc <= 1; dc++)
            begin
                idx = int'(p) + dr * int'(frm_w) + dc;
                if ((dr != 0 || dc != 0) && grad_mem[idx % STORE_N] == PIX_MAX)
                    return PIX_MAX;
            end
        return PIX_ZERO;
    endfunction

    task automatic edge_step(opcode_t op, logic [PIX_W-1:0] pix);
        int unsigned n, total, q, p;
        edge_res_t r;
        if (item_n == 0)
        begin
            frm_w = dim_clamp(cfg_w, DEF_MAX_WIDTH);
            frm_h = dim_clamp(cfg_h, DEF_MAX_HEIGHT);
            col_n = 0;
            row_n = 0;
        end
        n = item_n;
        total = frm_w * frm_h;
        if (op == OP_DRAIN && n < total)
            return;
        if (n < total)
            raw_mem[n % STORE_N] = pix;
        if (n >= frm_w)
        begin
            q = n - frm_w;
            if (q < total)
                grad_mem[q % STORE_N] = grad_class(q);
        end
        if (n >= 2 * frm_w + 1)
        begin
            p = n - 2 * frm_w - 1;
            r.pix  = hysteresis(p, row_n, col_n);
            r.last = (p >= total - 1);
            edge_q.push_back(r);
            if (r.last)
            begin
                item_n = 0;
                col_n  = 0;
                row_n  = 0;
                return;
            end
            col_n++;
            if (col_n >= frm_w)
            begin
                col_n = 0;
                row_n++;
            end
        end
        item_n = n + 1;
    endtask

    // ---------------- request side ----------------
    pix_req_t    pend [$];
    bit          took_item;
    bit          steady;
    int unsigned accepted, results_seen, errors, frames, req_count;
    int unsigned cycles;
    int unsigned gen_w = 640;
    int unsigned gen_h = 480;

    always @(posedge clk)
    begin
        took_item = rst_n && in_valid && !in_stall;
        if (took_item)
        begin
            edge_step(opcode, pixel_in);
            accepted++;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:  cfg_w  = cfg_data;
                REG_HEIGHT: cfg_h  = cfg_data;
                REG_LOW:    cfg_lo = cfg_data[TH_W-1:0];
                REG_HIGH:   cfg_hi = cfg_data[TH_W-1:0];
                default: ;
            endcase
        end
    end

    always @(negedge clk)
    begin : feed
        pix_req_t req;
        if (rst_n && (!in_valid || took_item))
        begin
            if (pend.size() != 0 && (steady || $urandom_range(99) >= 24))
            begin
                req = pend.pop_front();
                in_valid <= 1'b1;
                opcode   <= req.op;
                pixel_in <= req.pix;
            end
            else
            begin
                in_valid <= 1'b0;
                opcode   <= opcode_t'($urandom_range(1));
                pixel_in <= PIX_W'($urandom_range(255));
            end
        end
    end

    // ---------------- result side ----------------
    always @(negedge clk)
        out_stall <= rst_n && !steady && ($urandom_range(99) < 24);

    always @(posedge clk)
    begin : check
        edge_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (edge_q.size() == 0)
            begin
                $error("unexpected result: pixel_out=%0d frame_end=%0b", pixel_out, frame_end);
                errors++;
            end
            else
            begin
                want = edge_q.pop_front();
                results_seen++;
                if (pixel_out !== want.pix)
                begin
                    $error("pixel_out: expected %0d, actual %0d", want.pix, pixel_out);
                    errors++;
                end
                if (frame_end !== want.last)
                begin
                    $error("frame_end: expected %0b, actual %0b", want.last, frame_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("gradient_double_threshold_edges: mismatch");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic push_req(opcode_t op, logic [PIX_W-1:0] pix);
        pix_req_t r;
        r.op  = op;
        r.pix = pix;
        pend.push_back(r);
    endtask

    // sender stops, every expected pixel drains out, pipeline empties
    task automatic settle();
        do
            @(posedge clk);
        while (pend.size() != 0 || in_valid || edge_q.size() != 0);
        repeat (FLUSH_CYC) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        gen_w = dim_clamp(w % 2048, DEF_MAX_WIDTH);
        gen_h = dim_clamp(h % 2048, DEF_MAX_HEIGHT);
    endtask

    task automatic set_thresholds(int unsigned lo, int unsigned hi);
        write_reg(REG_LOW, lo);
        write_reg(REG_HIGH, hi);
    endtask

    function automatic int unsigned pick_dim(int unsigned top);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return $urandom_range(2);       // below minimum, clamps to 3
        if (roll < 15)
            return $urandom_range(11, 48);
        return $urandom_range(MIN_DIM, top);
    endfunction

    function automatic int unsigned pick_thresh();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 0;
        if (roll < 20)
            return TH_TOP;
        if (roll < 25)
            return (1 << TH_W) - 1;
        return $urandom_range(TH_TOP);
    endfunction

    // one full frame plus its flush; mid = 1 rewrites geometry halfway, 2 thresholds
    task automatic queue_frame(int unsigned w, int unsigned h, int unsigned style,
                               int unsigned mid);
        int unsigned k, total;
        int walk;
        logic [PIX_W-1:0] px;
        total = w * h;
        walk  = $urandom_range(255);
        for (k = 0; k < total; k++)
        begin
            if (mid != 0 && k == total / 2)
            begin
                settle();
                if (mid == 1)
                    set_geometry(pick_dim(10), pick_dim(8));
                else
                    set_thresholds(pick_thresh(), pick_thresh());
            end
            if ($urandom_range(99) < 4)
                push_req(OP_DRAIN, PIX_W'($urandom_range(255)));  // early drain, ignored
            case (style)
                0: px = PIX_W'($urandom_range(255));
                1:
                begin
                    walk = walk + int'($urandom_range(40)) - 20;
                    walk = (walk < 0) ? 0 : (walk > 255) ? 255 : walk;
                    px = PIX_W'(walk);
                end
                2: px = $urandom_range(1) ? PIX_MAX : PIX_ZERO;
                default: px = PIX_W'(128 + $urandom_range(30) - 15);
            endcase
            push_req(OP_PIXEL, px);
            req_count++;
        end
        // flush: pixels past the frame end act as drains
        for (k = 0; k < 2 * w + 1; k++)
        begin
            if ($urandom_range(1))
                push_req(OP_DRAIN, PIX_W'($urandom_range(255)));
            else
                push_req(OP_PIXEL, PIX_W'($urandom_range(255)));
            req_count++;
        end
        if ($urandom_range(9) == 0)
            push_req(OP_DRAIN, PIX_W'($urandom_range(255)));
        frames++;
    endtask

    // ---------------- test sequence ----------------
    initial
    begin
        logic [PIX_W-1:0] corner [0:8];
        int unsigned rand_start, fidx, k;
        corner = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd170, 8'd0, 8'd200, 8'd255};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // smallest frame via clamped geometry; thresholds low 0 and high TH_TOP
        set_geometry(2, 1);
        set_thresholds(0, TH_TOP);
        push_req(OP_DRAIN, 8'h5a);
        for (k = 0; k < 9; k++)
            push_req(OP_PIXEL, corner[k]);
        push_req(OP_PIXEL, 8'd77);
        repeat (6) push_req(OP_DRAIN, 8'h00);
        push_req(OP_DRAIN, 8'hff);
        req_count += 16;
        frames++;
        settle();

        // wide short frame with height clamped up, thresholds rewritten mid-frame
        set_geometry(40, 0);
        set_thresholds(12, 50);
        queue_frame(gen_w, gen_h, 1, 2);
        settle();

        // narrow tall frame, low above high, geometry rewritten mid-frame
        set_geometry(3, 40);
        set_thresholds((1 << TH_W) - 1, 0);
        queue_frame(gen_w, gen_h, 0, 1);

        rand_start = req_count;
        fidx = 0;
        while (req_count - rand_start < RAND_REQS)
        begin
            do
                @(posedge clk);
            while (pend.size() != 0);
            steady = (fidx >= 4 && fidx < 9);
            if ($urandom_range(2) == 0)
            begin
                settle();
                set_geometry(pick_dim(10), pick_dim(8));
                set_thresholds(pick_thresh(), pick_thresh());
            end
            queue_frame(gen_w, gen_h, $urandom_range(3),
                        ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0);
            fidx++;
        end
        steady = 1'b0;

        settle();
        repeat (FLUSH_CYC) @(posedge clk);
        $display("%0d frames, %0d requests accepted, %0d edge pixels compared", frames,
                 accepted, results_seen);
        $display("small, wide and tall frames incl. clamped geometry, thresholds 0 to 511, mid-frame writes");
        if (errors == 0)
            $display("gradient_double_threshold_edges: match");
        else
            $display("gradient_double_threshold_edges: mismatch");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/gdte_pkg.sv
design/gdte_ctrl.sv
design/gdte_pass_one.sv
design/gdte_pass_two.sv
design/gradient_double_threshold_edges.sv
sim/tb_gradient_double_threshold_edges.sv
